### hdl/kmab_pkg.sv
`default_nettype none

package kmab_pkg;

  localparam int WAYS    = 8;
  localparam int LEAVES  = 8;
  localparam int SRC_W   = 3;
  localparam int VTX_W   = 30;
  localparam int POS_W   = 36;
  localparam int DEG_W   = 31;
  localparam int WORDS_W = 34;
  localparam int CNT_W   = $clog2(WAYS + 1);
  localparam int MAX_RES = 3;

  typedef enum logic [1:0] {
    KIND_NEIGHBOR,
    KIND_START,
    KIND_DEGREE,
    KIND_SUMMARY
  } kind_t;

  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic [VTX_W-1:0] edge_from;
    logic [VTX_W-1:0] edge_to;
    logic             exhausted;
    logic             do_pop;
  } cmd_t;

  typedef struct packed {
    logic             live;
    logic [SRC_W-1:0] idx;
    logic [VTX_W-1:0] from;
    logic [VTX_W-1:0] to;
  } cand_t;

  typedef struct packed {
    kind_t            kind;
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] neighbor;
    logic [POS_W-1:0] position;
    logic [DEG_W-1:0] degree;
    logic [DEG_W-1:0] max_degree;
    logic [DEG_W-1:0] vertex_count;
    logic [SRC_W-1:0] refill_source;
    logic             last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TREE,
    ST_PICK,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic cmd_pop;
    logic head_wr;
    logic tree_ld;
    logic pick_ld;
    logic emit_ld;
  } back_ctrl_t;

  // The right candidate wins only when strictly smaller, so ties keep the lower run.
  function automatic cand_t pick_cand(cand_t a, cand_t b);
    logic b_wins;
    b_wins = b.live && (!a.live || ({b.from, b.to} < {a.from, a.to}));
    return b_wins ? b : a;
  endfunction

endpackage

`default_nettype wire

### hdl/kmab_front.sv
`default_nettype none

module kmab_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic                        q_full,
  input  wire logic [kmab_pkg::SRC_W-1:0]  in_source,
  input  wire logic [kmab_pkg::VTX_W-1:0]  in_edge_from,
  input  wire logic [kmab_pkg::VTX_W-1:0]  in_edge_to,
  input  wire logic                        in_exhausted,
  output logic                             q_wr,
  output kmab_pkg::cmd_t                   q_cmd
);

  logic [kmab_pkg::CNT_W-1:0] loaded_r;
  logic [kmab_pkg::CNT_W-1:0] loaded_nxt;
  logic                       accept;
  logic                       in_range;
  logic                       all_loaded;

  assign accept     = push && !q_full;
  assign in_range   = int'(in_source) < kmab_pkg::WAYS;
  assign all_loaded = loaded_r == kmab_pkg::CNT_W'(kmab_pkg::WAYS);

  // An out-of-range run is dropped here and never reaches the merge side.
  assign q_wr = accept && in_range;

  always_comb begin
    q_cmd.source    = in_source;
    q_cmd.edge_from = in_edge_from;
    q_cmd.edge_to   = in_edge_to;
    q_cmd.exhausted = in_exhausted;
    q_cmd.do_pop    = all_loaded ||
                      (loaded_r == kmab_pkg::CNT_W'(kmab_pkg::WAYS - 1));
  end

  always_comb begin
    loaded_nxt = loaded_r;
    if (q_wr && !all_loaded) begin
      loaded_nxt = loaded_r + kmab_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else begin
      loaded_r <= loaded_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/kmab_queue.sv
`default_nettype none

module kmab_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire kmab_pkg::cmd_t wr_data,
  output logic                full,
  output logic                rd_valid,
  input  wire logic           rd_en,
  output kmab_pkg::cmd_t      rd_data
);

  kmab_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           do_wr;
  logic           do_rd;

  assign full     = count_r == 2'd2;
  assign rd_valid = count_r != 2'd0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/kmab_back.sv
`default_nettype none

module kmab_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire kmab_pkg::cmd_t q_cmd,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output kmab_pkg::result_t   out_res
);

  kmab_pkg::back_state_t state_r;
  kmab_pkg::back_state_t state_nxt;
  kmab_pkg::back_ctrl_t  ctrl;

  logic [kmab_pkg::VTX_W-1:0] head_from_r [kmab_pkg::LEAVES];
  logic [kmab_pkg::VTX_W-1:0] head_to_r   [kmab_pkg::LEAVES];
  logic [kmab_pkg::LEAVES-1:0] head_live_r;

  logic [kmab_pkg::VTX_W-1:0]   prev_from_r;
  logic [kmab_pkg::VTX_W-1:0]   prev_to_r;
  logic                         have_vertex_r;
  logic [kmab_pkg::DEG_W-1:0]   run_degree_r;
  logic [kmab_pkg::DEG_W-1:0]   best_degree_r;
  logic [kmab_pkg::WORDS_W-1:0] words_written_r;
  logic                         finished_r;

  kmab_pkg::cand_t   leaf   [kmab_pkg::LEAVES];
  kmab_pkg::cand_t   lvl1   [4];
  kmab_pkg::cand_t   lvl2   [2];
  kmab_pkg::cand_t   tree_r [2];
  kmab_pkg::cand_t   fin;

  kmab_pkg::result_t res_nxt [kmab_pkg::MAX_RES];
  kmab_pkg::result_t res_r   [kmab_pkg::MAX_RES];
  logic [1:0]        res_n;
  logic [1:0]        res_cnt_r;
  logic [1:0]        emit_idx_r;
  logic              last_emit;

  logic [kmab_pkg::DEG_W-1:0] best_new;
  logic                       new_vertex;
  logic                       new_edge;
  logic [kmab_pkg::DEG_W-1:0] run_inc;

  kmab_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              out_free;

  assign out_free  = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign out_res   = out_res_r;
  assign q_pop     = ctrl.cmd_pop;
  assign last_emit = emit_idx_r == (res_cnt_r - 2'd1);

  // Two compare levels of the selection tree.
  always_comb begin
    for (int i = 0; i < kmab_pkg::LEAVES; i++) begin
      leaf[i].live = head_live_r[i];
      leaf[i].idx  = kmab_pkg::SRC_W'(i);
      leaf[i].from = head_from_r[i];
      leaf[i].to   = head_to_r[i];
    end
    for (int j = 0; j < 4; j++) begin
      lvl1[j] = kmab_pkg::pick_cand(leaf[2*j], leaf[2*j+1]);
    end
    for (int j = 0; j < 2; j++) begin
      lvl2[j] = kmab_pkg::pick_cand(lvl1[2*j], lvl1[2*j+1]);
    end
  end

  // Final compare and the result list for this pop.
  always_comb begin
    fin        = kmab_pkg::pick_cand(tree_r[0], tree_r[1]);
    best_new   = (have_vertex_r && (run_degree_r > best_degree_r)) ?
                 run_degree_r : best_degree_r;
    new_vertex = !have_vertex_r || (fin.from != prev_from_r);
    new_edge   = fin.to != prev_to_r;
    run_inc    = (run_degree_r == '1) ? run_degree_r :
                 run_degree_r + kmab_pkg::DEG_W'(1);
    res_n      = 2'd0;
    for (int k = 0; k < kmab_pkg::MAX_RES; k++) begin
      res_nxt[k] = '0;
    end
    if (!fin.live) begin
      if (have_vertex_r) begin
        res_nxt[res_n].kind   = kmab_pkg::KIND_DEGREE;
        res_nxt[res_n].degree = run_degree_r;
        res_n = res_n + 2'd1;
      end
      res_nxt[res_n].kind         = kmab_pkg::KIND_SUMMARY;
      res_nxt[res_n].max_degree   = best_new;
      res_nxt[res_n].vertex_count = have_vertex_r ?
                                    ({1'b0, prev_from_r} + kmab_pkg::DEG_W'(1)) : '0;
      res_n = res_n + 2'd1;
      res_nxt[res_n - 2'd1].last = 1'b1;
    end else begin
      if (new_vertex) begin
        if (have_vertex_r) begin
          res_nxt[res_n].kind   = kmab_pkg::KIND_DEGREE;
          res_nxt[res_n].degree = run_degree_r;
          res_n = res_n + 2'd1;
        end
        res_nxt[res_n].kind     = kmab_pkg::KIND_START;
        res_nxt[res_n].vertex   = fin.from;
        res_nxt[res_n].position = {words_written_r, 2'b00};
        res_n = res_n + 2'd1;
        res_nxt[res_n].kind     = kmab_pkg::KIND_NEIGHBOR;
        res_nxt[res_n].neighbor = fin.to;
        res_nxt[res_n].degree   = kmab_pkg::DEG_W'(1);
        res_n = res_n + 2'd1;
      end else begin
        res_nxt[res_n].kind     = kmab_pkg::KIND_NEIGHBOR;
        res_nxt[res_n].neighbor = fin.to;
        res_nxt[res_n].degree   = new_edge ? kmab_pkg::DEG_W'(1) : kmab_pkg::DEG_W'(0);
        res_n = res_n + 2'd1;
      end
      res_nxt[res_n - 2'd1].last          = 1'b1;
      res_nxt[res_n - 2'd1].refill_source = fin.idx;
    end
  end

  // Control strobes.
  always_comb begin
    ctrl = '0;
    case (state_r)
      kmab_pkg::ST_IDLE: begin
        if (q_valid) begin
          ctrl.cmd_pop = 1'b1;
          ctrl.head_wr = !finished_r;
        end
      end
      kmab_pkg::ST_TREE: ctrl.tree_ld = 1'b1;
      kmab_pkg::ST_PICK: ctrl.pick_ld = 1'b1;
      kmab_pkg::ST_EMIT: ctrl.emit_ld = out_free;
      default: ctrl = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kmab_pkg::ST_IDLE: begin
        if (q_valid && !finished_r && q_cmd.do_pop) begin
          state_nxt = kmab_pkg::ST_TREE;
        end
      end
      kmab_pkg::ST_TREE: state_nxt = kmab_pkg::ST_PICK;
      kmab_pkg::ST_PICK: state_nxt = kmab_pkg::ST_EMIT;
      kmab_pkg::ST_EMIT: begin
        if (out_free && last_emit) begin
          state_nxt = kmab_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kmab_pkg::ST_IDLE;
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.head_wr && !q_cmd.exhausted) begin
      head_from_r[q_cmd.source] <= q_cmd.edge_from;
      head_to_r[q_cmd.source]   <= q_cmd.edge_to;
    end
    if (ctrl.tree_ld) begin
      tree_r[0] <= lvl2[0];
      tree_r[1] <= lvl2[1];
    end
    if (ctrl.pick_ld) begin
      for (int k = 0; k < kmab_pkg::MAX_RES; k++) begin
        res_r[k] <= res_nxt[k];
      end
    end
    if (ctrl.emit_ld) begin
      out_res_r <= res_r[emit_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= kmab_pkg::ST_IDLE;
      head_live_r     <= '0;
      prev_from_r     <= '0;
      prev_to_r       <= '0;
      have_vertex_r   <= 1'b0;
      run_degree_r    <= '0;
      best_degree_r   <= '0;
      words_written_r <= '0;
      finished_r      <= 1'b0;
      res_cnt_r       <= 2'd0;
      emit_idx_r      <= 2'd0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.head_wr) begin
        head_live_r[q_cmd.source] <= !q_cmd.exhausted;
      end
      if (ctrl.pick_ld) begin
        res_cnt_r  <= res_n;
        emit_idx_r <= 2'd0;
        if (!fin.live) begin
          finished_r    <= 1'b1;
          best_degree_r <= best_new;
        end else begin
          if (new_vertex) begin
            best_degree_r   <= best_new;
            words_written_r <= words_written_r + kmab_pkg::WORDS_W'(1);
            run_degree_r    <= kmab_pkg::DEG_W'(1);
            have_vertex_r   <= 1'b1;
          end else if (new_edge) begin
            words_written_r <= words_written_r + kmab_pkg::WORDS_W'(1);
            run_degree_r    <= run_inc;
          end
          prev_from_r          <= fin.from;
          prev_to_r            <= fin.to;
          head_live_r[fin.idx] <= 1'b0;
        end
      end
      if (ctrl.emit_ld) begin
        emit_idx_r  <= emit_idx_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/kway_merge_adjacency_builder_unit.sv
// Path: a refill request passes the command queue, the head store, the registered selection
// tree and the result list before its first result reaches the output register, which the
// pop side can stall. A refill emits one to three results; while it runs, the two-entry queue
// still takes new requests. Reset: rst_n is synchronous and active low; it clears all control
// and merge state, and the head edge stores stay undefined until their run is first written.
`default_nettype none

module kway_merge_adjacency_builder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [kmab_pkg::SRC_W-1:0]  in_source,
  input  wire logic [kmab_pkg::VTX_W-1:0]  in_edge_from,
  input  wire logic [kmab_pkg::VTX_W-1:0]  in_edge_to,
  input  wire logic                        in_exhausted,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [1:0]                       out_kind,
  output logic [kmab_pkg::VTX_W-1:0]       out_vertex,
  output logic [kmab_pkg::VTX_W-1:0]       out_neighbor,
  output logic [kmab_pkg::POS_W-1:0]       out_position,
  output logic [kmab_pkg::DEG_W-1:0]       out_degree,
  output logic [kmab_pkg::DEG_W-1:0]       out_max_degree,
  output logic [kmab_pkg::DEG_W-1:0]       out_vertex_count,
  output logic [kmab_pkg::SRC_W-1:0]       out_refill_source,
  output logic                             out_last
);

  // The front side checks the run index and counts the loading phase, so each request that
  // survives enters the command queue already marked as a plain load or a load plus a pop.
  logic           q_wr;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  kmab_pkg::cmd_t q_wr_cmd;
  kmab_pkg::cmd_t q_rd_cmd;

  // The back side owns the head edges and the running vertex state. It writes one head and, for
  // a command marked with a pop, then runs the selection tree over all heads in two registered
  // steps, builds the list of results for the pop and hands them one at a time to the output register.
  kmab_pkg::result_t res;

  assign full = q_full;

  kmab_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .q_full       (q_full),
    .in_source    (in_source),
    .in_edge_from (in_edge_from),
    .in_edge_to   (in_edge_to),
    .in_exhausted (in_exhausted),
    .q_wr         (q_wr),
    .q_cmd        (q_wr_cmd)
  );

  // A two-entry queue lets new requests land while the back side is still busy with a pop.
  kmab_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_wr_cmd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_rd_cmd)
  );

  // Once the summary has gone out, the back side drains and drops every further command.
  kmab_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_rd_cmd),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_res (res)
  );

  assign out_kind          = res.kind;
  assign out_vertex        = res.vertex;
  assign out_neighbor      = res.neighbor;
  assign out_position      = res.position;
  assign out_degree        = res.degree;
  assign out_max_degree    = res.max_degree;
  assign out_vertex_count  = res.vertex_count;
  assign out_refill_source = res.refill_source;
  assign out_last          = res.last;

endmodule

`default_nettype wire
